>>> sv/nms_pkg.sv
// ============================================================================
// nms_pkg: shared types and constants for the needle motor sequencer
// Beat structs, phase codes, register indexes, reset values and the
// fixed-point helpers for the speed scaling and the low-pass.
// ============================================================================
package nms_pkg;

    // Phase codes as seen on the result beat
    typedef enum logic [2:0] {
        PH_WAIT    = 3'd0,
        PH_STANDBY = 3'd1,
        PH_CUTTING = 3'd2,
        PH_REMOVAL = 3'd3,
        PH_EXITING = 3'd4,
        PH_FINISH  = 3'd5,
        PH_ZERO    = 3'd6
    } t_phase;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_FWD_LIMIT  = 3'd0,
        CFG_BWD_LIMIT  = 3'd1,
        CFG_STALL_MA   = 3'd2,
        CFG_DEBOUNCE   = 3'd3,
        CFG_HOLD       = 3'd4
    } t_cfg_idx;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;

    typedef struct packed {
        logic               button_level;
        logic               button_press_edge;
        logic               button_release_edge;
        logic [3:0]         encoder_pulses;
        logic signed [15:0] current_sample;
        logic [6:0]         speed_percent;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]         phase;
        logic               motor_forward;
        logic [7:0]         motor_duty;
        logic signed [23:0] position;
        logic signed [15:0] window_mean;
        logic signed [23:0] smoothed_current;
    } t_out_beat;

    typedef struct packed {
        logic signed [23:0] fwd_limit;
        logic signed [23:0] bwd_limit;
        logic [14:0]        stall_ma;
        logic [15:0]        debounce;
        logic [23:0]        hold;
    } t_cfg;

    // Filter controls from the sequencer to the current filters
    typedef struct packed {
        logic clear;      // zero the window and the low-pass
        logic lp_update;  // run one low-pass step
    } t_filt_ctl;

    localparam logic signed [23:0] FWD_LIMIT_RST = 24'sd20408;
    localparam logic signed [23:0] BWD_LIMIT_RST = 24'sd0;
    localparam logic [14:0]        STALL_MA_RST  = 15'd1000;
    localparam logic [15:0]        DEBOUNCE_RST  = 16'd50;
    localparam logic [23:0]        HOLD_RST      = 24'd2000;

    localparam logic [23:0] TIMER_MAX = 24'hFF_FFFF;
    localparam logic [7:0]  DUTY_FULL = 8'hFF;

    // floor(x/100) for x < 2^15 as (x * ceil(2^22/100)) >> 22
    localparam logic [15:0] SPD_RECIP = 16'd41944;
    localparam int unsigned SPD_SHIFT = 22;

    // Low-pass: floor(num/10) via bias to non-negative, then
    // (x * ceil(2^35/10)) >> 35, then remove the biased quotient.
    localparam logic [31:0]        LP_BIAS   = 32'd1342177280;  // 10 * 2^27
    localparam logic [31:0]        LP_RECIP  = 32'd3435973837;
    localparam int unsigned        LP_SHIFT  = 35;
    localparam logic signed [31:0] LP_BIAS_Q = 32'sd134217728;  // 2^27
    localparam logic signed [31:0] LP_MAX    = 32'sd8388607;
    localparam logic signed [31:0] LP_MIN    = -32'sd8388608;

    // Duty level = floor(percent * 255 / 100), saturated at full scale
    function automatic logic [7:0] speed_level_f(input logic [6:0] pct);
        logic [14:0] scaled;
        logic [30:0] prod;
        logic [8:0]  quo;
        scaled = {pct, 8'h00} - {8'h00, pct};
        prod   = 31'(scaled) * 31'(SPD_RECIP);
        quo    = prod[SPD_SHIFT +: 9];
        return (quo > 9'd255) ? DUTY_FULL : quo[7:0];
    endfunction

endpackage

>>> sv/nms_ctrl.sv
// ============================================================================
// nms_ctrl: phase sequencer, button debounce and position count
// Handles press/release/long hold, steps the phase, drives direction and
// duty, and keeps the signed encoder position.
// ============================================================================
module nms_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  nms_pkg::t_cfg     i_cfg,
    input  nms_pkg::t_in_beat i_beat,
    output nms_pkg::t_filt_ctl o_filt,
    output logic [2:0]        o_phase,
    output logic              o_forward,
    output logic [7:0]        o_duty,
    output logic [23:0]       o_position
);
    import nms_pkg::*;

    t_phase      r_phase,   n_phase;
    t_phase      r_pending, n_pending;
    logic        r_press_pending, n_press_pending;
    logic        r_press_valid,   n_press_valid;
    logic [23:0] r_press_timer,   n_press_timer;
    logic [23:0] r_position,      n_position;
    logic [7:0]  r_speed,         n_speed;
    logic        r_dir,           n_dir;
    logic [7:0]  r_duty,          n_duty;

    t_phase      ph_btn;     // phase after release and long-hold handling
    logic [23:0] pos_moved;  // position after this beat's pulses
    logic        pp_arm;
    logic [23:0] pt_arm;
    logic        pos_zero;
    logic        stalled;

    // button handling: release acts on the earlier press state
    always_comb begin
        pp_arm          = r_press_pending | i_beat.button_press_edge;
        pt_arm          = i_beat.button_press_edge ? '0 : r_press_timer;
        ph_btn          = r_phase;
        n_press_valid   = r_press_valid;
        n_press_pending = pp_arm;
        if (i_beat.button_release_edge && r_press_valid) begin
            ph_btn        = r_pending;
            n_press_valid = 1'b0;
        end
        if (pp_arm) begin
            if (pt_arm >= 24'(i_cfg.debounce)) begin
                if (i_beat.button_level) begin
                    n_press_valid = 1'b1;
                end else begin
                    n_press_pending = 1'b0;
                end
            end
            if (n_press_valid && (pt_arm >= i_cfg.hold)) begin
                ph_btn          = PH_ZERO;
                n_press_pending = 1'b0;
                n_press_valid   = 1'b0;
            end
        end
        n_press_timer = (n_press_pending && (pt_arm != TIMER_MAX)) ? pt_arm + 24'd1
                                                                    : pt_arm;
    end

    assign pos_moved = r_dir ? r_position + 24'(i_beat.encoder_pulses)
                             : r_position - 24'(i_beat.encoder_pulses);
    assign stalled   = i_beat.current_sample > $signed({1'b0, i_cfg.stall_ma});

    // next phase
    always_comb begin
        case (ph_btn)
            PH_STANDBY: n_phase = PH_STANDBY;
            PH_CUTTING: n_phase = ($signed(pos_moved) > i_cfg.fwd_limit) ? PH_REMOVAL
                                                                          : PH_CUTTING;
            PH_REMOVAL: n_phase = PH_REMOVAL;
            PH_EXITING: n_phase = ($signed(pos_moved) < i_cfg.bwd_limit) ? PH_FINISH
                                                                          : PH_EXITING;
            PH_FINISH:  n_phase = PH_FINISH;
            PH_ZERO:    n_phase = stalled ? PH_FINISH : PH_ZERO;
            default:    n_phase = PH_WAIT;
        endcase
    end

    // per-phase outputs
    always_comb begin
        n_dir            = r_dir;
        n_duty           = r_duty;
        n_speed          = r_speed;
        n_pending        = r_pending;
        o_filt.clear     = 1'b0;
        o_filt.lp_update = 1'b0;
        pos_zero         = 1'b0;
        case (ph_btn)
            PH_STANDBY: begin
                n_dir        = 1'b1;
                n_duty       = '0;
                n_speed      = speed_level_f(i_beat.speed_percent);
                o_filt.clear = 1'b1;
                n_pending    = PH_CUTTING;
            end
            PH_CUTTING: begin
                o_filt.lp_update = 1'b1;
                n_dir            = (n_phase == PH_CUTTING);
                n_duty           = (n_phase == PH_CUTTING) ? r_speed : '0;
                n_pending        = PH_REMOVAL;
            end
            PH_REMOVAL: begin
                n_dir        = 1'b0;
                n_duty       = '0;
                n_speed      = speed_level_f(i_beat.speed_percent);
                o_filt.clear = 1'b1;
                n_pending    = PH_EXITING;
            end
            PH_EXITING: begin
                o_filt.lp_update = 1'b1;
                n_dir            = (n_phase != PH_EXITING);
                n_duty           = (n_phase == PH_EXITING) ? r_speed : '0;
                n_pending        = PH_FINISH;
            end
            PH_FINISH: begin
                n_dir     = 1'b1;
                n_duty    = '0;
                n_pending = PH_STANDBY;
            end
            PH_ZERO: begin
                n_dir     = 1'b0;
                n_duty    = DUTY_FULL;
                pos_zero  = stalled;
                n_pending = PH_FINISH;
            end
            default: begin
                n_dir     = 1'b1;
                n_duty    = '0;
                n_pending = PH_STANDBY;
            end
        endcase
    end

    assign n_position = pos_zero ? '0 : pos_moved;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_WAIT;
            r_pending       <= PH_STANDBY;
            r_press_pending <= 1'b0;
            r_press_valid   <= 1'b0;
            r_press_timer   <= '0;
            r_position      <= '0;
            r_speed         <= '0;
            r_dir           <= 1'b1;
            r_duty          <= '0;
        end else if (i_en) begin
            r_phase         <= n_phase;
            r_pending       <= n_pending;
            r_press_pending <= n_press_pending;
            r_press_valid   <= n_press_valid;
            r_press_timer   <= n_press_timer;
            r_position      <= n_position;
            r_speed         <= n_speed;
            r_dir           <= n_dir;
            r_duty          <= n_duty;
        end
    end

    assign o_phase    = n_phase;
    assign o_forward  = n_dir;
    assign o_duty     = n_duty;
    assign o_position = n_position;

endmodule

>>> sv/nms_window.sv
// ============================================================================
// nms_window: moving-window mean of the motor current
// Circular sample store with running total; mean by reciprocal multiply,
// truncated toward zero.
// ============================================================================
module nms_window #(
    parameter int unsigned WINDOW = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  nms_pkg::t_filt_ctl i_filt,
    input  logic signed [15:0] i_cur,
    output logic signed [15:0] o_mean
);
    import nms_pkg::*;

    localparam int unsigned IDX_W   = $clog2(WINDOW);
    localparam int unsigned TOTAL_W = 16 + $clog2(WINDOW);
    localparam int unsigned SHIFT   = TOTAL_W + $clog2(WINDOW);
    localparam int unsigned RECIP_W = SHIFT + 1;
    localparam longint unsigned RECIP_L = ((64'd1 << SHIFT) + WINDOW - 1) / WINDOW;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_L[RECIP_W-1:0];
    localparam logic [IDX_W-1:0]   IDX_LAST = IDX_W'(WINDOW - 1);

    logic signed [15:0]        r_samples [WINDOW];
    logic signed [TOTAL_W-1:0] r_total, n_total;
    logic [IDX_W-1:0]          r_idx, n_idx;

    logic                        neg;
    logic [TOTAL_W-1:0]          mag;
    logic [TOTAL_W+RECIP_W-1:0]  prod;
    logic [TOTAL_W-1:0]          quo;
    logic [TOTAL_W-1:0]          mean_full;

    assign n_total = r_total - TOTAL_W'(r_samples[r_idx]) + TOTAL_W'(i_cur);
    assign n_idx   = (r_idx == IDX_LAST) ? '0 : r_idx + 1'b1;

    // |total| / WINDOW, then sign restored
    assign neg       = n_total[TOTAL_W-1];
    assign mag       = neg ? (~n_total + 1'b1) : n_total;
    assign prod      = (TOTAL_W+RECIP_W)'(mag) * (TOTAL_W+RECIP_W)'(RECIP);
    assign quo       = prod[SHIFT +: TOTAL_W];
    assign mean_full = neg ? (~quo + 1'b1) : quo;
    assign o_mean    = mean_full[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_idx   <= '0;
            for (int i = 0; i < WINDOW; i++) begin
                r_samples[i] <= '0;
            end
        end else if (i_en) begin
            if (i_filt.clear) begin
                r_total <= '0;
                r_idx   <= '0;
                for (int i = 0; i < WINDOW; i++) begin
                    r_samples[i] <= '0;
                end
            end else begin
                r_total          <= n_total;
                r_idx            <= n_idx;
                r_samples[r_idx] <= i_cur;
            end
        end
    end

endmodule

>>> sv/nms_lowpass.sv
// ============================================================================
// nms_lowpass: Q15.8 low-pass of the motor current
// acc = floor((cur*256 + 9*acc + 5) / 10), saturated to 24 bits signed.
// ============================================================================
module nms_lowpass (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  nms_pkg::t_filt_ctl i_filt,
    input  logic signed [15:0] i_cur,
    output logic signed [23:0] o_acc
);
    import nms_pkg::*;

    logic signed [23:0] r_acc, n_acc;

    logic signed [31:0]   cur_x256;
    logic signed [31:0]   acc_x9;
    logic signed [31:0]   num;
    logic [31:0]          biased;
    logic [63:0]          prod;
    logic [63-LP_SHIFT:0] quo_b;
    logic signed [31:0]   quo;
    logic signed [23:0]   sat;

    assign cur_x256 = {{8{i_cur[15]}}, i_cur, 8'h00};
    assign acc_x9   = {{8{r_acc[23]}}, r_acc} + {{5{r_acc[23]}}, r_acc, 3'b000};
    assign num      = cur_x256 + acc_x9 + 32'sd5;
    // bias keeps the dividend non-negative so floor needs no sign fix-up
    assign biased   = $unsigned(num) + LP_BIAS;
    assign prod     = 64'(biased) * 64'(LP_RECIP);
    assign quo_b    = prod[63:LP_SHIFT];
    assign quo      = $signed(32'(quo_b)) - LP_BIAS_Q;

    always_comb begin
        if (quo > LP_MAX) begin
            sat = LP_MAX[23:0];
        end else if (quo < LP_MIN) begin
            sat = LP_MIN[23:0];
        end else begin
            sat = quo[23:0];
        end
    end

    assign n_acc = i_filt.clear     ? '0  :
                   i_filt.lp_update ? sat : r_acc;
    assign o_acc = n_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_en) begin
            r_acc <= n_acc;
        end
    end

endmodule

>>> sv/needle_motor_sequencer.sv
// ============================================================================
// needle_motor_sequencer: biopsy needle motor control, one beat per tick
// Top level: configuration registers, input register, sequencer, current
// filters and result register.
// ============================================================================
// One input beat is one control tick: button level and edges, encoder
// pulses, a current sample and the speed setting. Each beat yields exactly
// one result beat: phase, motor direction, duty, position, window mean and
// smoothed current. Throughput is one beat per clock unless the result
// side stalls; a beat is captured in the input register, all of its work
// (button debounce, phase step, position count, the window mean multiply
// and the low-pass reciprocal multiply) runs in one pass when the beat
// advances, and the result is registered in the output register. The output
// register decouples the two sides: a new beat is taken whenever the input
// register is empty or its beat moves into the result register in the same
// cycle. Configuration writes (i_cfg_we,
// i_cfg_idx, i_cfg_data) take effect at once and must only be issued while
// no beat is in flight; indexes 5 to 7 are ignored. WINDOW sets the length
// of the current averaging window (2 to 16).
// ============================================================================
module needle_motor_sequencer #(
    parameter int unsigned WINDOW = 5
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input beats
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  nms_pkg::t_in_beat                i_in_data,
    // result beats
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output nms_pkg::t_out_beat               o_out_data,
    // configuration writes
    input  logic                             i_cfg_we,
    input  logic [nms_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [nms_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import nms_pkg::*;

    t_cfg       r_cfg;
    t_in_beat   r_in;
    logic       r_in_valid;
    t_out_beat  r_out, n_out;
    logic       r_out_valid;
    logic       advance;   // input register beat moves into the result register

    t_filt_ctl          filt;
    logic [2:0]         phase;
    logic               forward;
    logic [7:0]         duty;
    logic [23:0]        position;
    logic signed [15:0] mean;
    logic signed [23:0] smoothed;

    // ---------------- configuration registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fwd_limit <= FWD_LIMIT_RST;
            r_cfg.bwd_limit <= BWD_LIMIT_RST;
            r_cfg.stall_ma  <= STALL_MA_RST;
            r_cfg.debounce  <= DEBOUNCE_RST;
            r_cfg.hold      <= HOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FWD_LIMIT: r_cfg.fwd_limit <= $signed(i_cfg_data);
                CFG_BWD_LIMIT: r_cfg.bwd_limit <= $signed(i_cfg_data);
                CFG_STALL_MA:  r_cfg.stall_ma  <= i_cfg_data[14:0];
                CFG_DEBOUNCE:  r_cfg.debounce  <= i_cfg_data[15:0];
                CFG_HOLD:      r_cfg.hold      <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // input register: payload only loads on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    // ---------------- per-tick work ----------------
    nms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (advance),
        .i_cfg      (r_cfg),
        .i_beat     (r_in),
        .o_filt     (filt),
        .o_phase    (phase),
        .o_forward  (forward),
        .o_duty     (duty),
        .o_position (position)
    );

    nms_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_filt  (filt),
        .i_cur   (r_in.current_sample),
        .o_mean  (mean)
    );

    nms_lowpass u_lowpass (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_filt  (filt),
        .i_cur   (r_in.current_sample),
        .o_acc   (smoothed)
    );

    // ---------------- result register ----------------
    always_comb begin
        n_out.phase            = phase;
        n_out.motor_forward    = forward;
        n_out.motor_duty       = duty;
        n_out.position         = $signed(position);
        n_out.window_mean      = mean;
        n_out.smoothed_current = smoothed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> sv/nms_checker.sv
// ============================================================================
// nms_checker: port-level checks for needle_motor_sequencer
// Watches the result channel over time; bound to the top level.
// ============================================================================
module nms_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input nms_pkg::t_out_beat o_out_data
);
    import nms_pkg::*;

    // a stalled result beat stays up and unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat dropped or changed while stalled");

    // no result beat right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // homing always drives backward at full duty
    a_zero_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.phase == PH_ZERO)
        |-> !o_out_data.motor_forward && (o_out_data.motor_duty == DUTY_FULL))
        else $error("homing phase not driving backward at full duty");

    // idle phases keep the motor stopped
    a_idle_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_out_data.phase == PH_WAIT) ||
                        (o_out_data.phase == PH_STANDBY) ||
                        (o_out_data.phase == PH_REMOVAL))
        |-> (o_out_data.motor_duty == 8'd0))
        else $error("motor driven in an idle phase");

endmodule

bind needle_motor_sequencer nms_checker u_nms_checker (.*);
